### design/smst_pkg.sv
// shared types for the sorted mark set table
`default_nettype none
package smst_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT,
    ST_DRAIN,
    ST_PUT,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

### design/smst_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module smst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### design/sorted_mark_set_table.sv
// sorted mark set table: top level with search and shift sequencer
`default_nettype none
// Keeps an ascending, duplicate-free table of up to CAPACITY line numbers in
// a single ram. A request (op_i, line_i) is taken when start_i is high and
// busy_o is low; busy_o stays high until the result has been shown. Each
// request first runs a lower-bound binary search, each step a ram read, then
// a compare, at most clog2(CAPACITY+1) steps, plus a last ST_SRCH_RD visit
// that sees the window close. An insert or a delete then moves the entries
// behind the position by one place, one entry a cycle through the ram's read
// and write ports, then drains the last move when there was one and, for an
// insert, writes the new line in ST_PUT. ST_DONE, which shows the result,
// follows. At the default size the longest request is a delete at the front
// of a full table, and the next request is taken once the block is back in
// idle. A query, a clear or an edit that changes nothing is busy for the
// search and ST_DONE only. The result is flagged by done_o for exactly one
// cycle, and the receiver cannot hold it off. Only the low min(LINE_BITS, 32)
// bits of line_i are used. position_o and entry_count_o carry the low seven
// bits of their values.
module sorted_mark_set_table #(
  parameter int CAPACITY  = 64,
  parameter int LINE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] line_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [6:0]       position_o,
  output logic             was_present_o,
  output logic             now_present_o,
  output logic             rejected_full_o,
  output logic [6:0]       entry_count_o
);
  import smst_pkg::*;

  localparam int KW = (LINE_BITS < 32) ? LINE_BITS : 32;  // stored key width
  localparam int AW = $clog2(CAPACITY);                     // ram address bits
  localparam int CW = $clog2(CAPACITY + 1);                 // count / index bits
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] occ_q, occ_d;
  logic          pend_v_q, pend_v_d;

  // payload registers
  logic [KW-1:0] key_q, key_d;
  logic [2:0]    op_q, op_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] mid_q, mid_d;
  logic          eq_q, eq_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          ins_q, ins_d;
  logic [CW-1:0] pend_addr_q, pend_addr_d;
  logic          was_q, was_d;
  logic          now_q, now_d;
  logic          rej_q, rej_d;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_rdata;

  // shared datapath terms
  logic [CW-1:0] mid;
  logic [CW-1:0] src;
  logic          last_move;

  // midpoint of the live search window
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // source of the move in flight: entry behind for insert, ahead for delete
  assign src = ins_q ? (idx_q - CW'(1)) : (idx_q + CW'(1));

  // insert stops once the slot at the position is free, delete once the
  // last valid entry has been pulled forward
  assign last_move = ins_q ? (src == lo_q)
                           : (({1'b0, idx_q} + (CW + 1)'(2)) == {1'b0, occ_q});

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    pend_v_d    = 1'b0;
    key_d       = key_q;
    op_d        = op_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    eq_d        = eq_q;
    idx_d       = idx_q;
    ins_d       = ins_q;
    pend_addr_d = pend_addr_q;
    was_d       = was_q;
    now_d       = now_q;
    rej_d       = rej_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = line_i[KW-1:0];
          op_d    = op_i;
          lo_d    = '0;
          hi_d    = occ_q;
          eq_d    = 1'b0;
          state_d = ST_SRCH_RD;
        end
      end

      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          mid_d   = mid;
          state_d = ST_SRCH_CMP;
        end else begin
          // search done: lo_q is the position, eq_q tells if the line is there
          was_d   = eq_q;
          now_d   = eq_q;
          rej_d   = 1'b0;
          state_d = ST_DONE;
          case (op_q)
            OP_ADD, OP_TOGGLE: begin
              if (!eq_q) begin
                if (occ_q >= CAP) begin
                  rej_d = 1'b1;
                end else begin
                  now_d = 1'b1;
                  ins_d = 1'b1;
                  idx_d = occ_q;
                  state_d = (occ_q > lo_q) ? ST_SHIFT : ST_PUT;
                end
              end else if (op_q == OP_TOGGLE) begin
                now_d = 1'b0;
                ins_d = 1'b0;
                idx_d = lo_q;
                if (({1'b0, lo_q} + (CW + 1)'(1)) < {1'b0, occ_q}) begin
                  state_d = ST_SHIFT;
                end else begin
                  occ_d = occ_q - CW'(1);
                end
              end
            end
            OP_DELETE: begin
              if (eq_q) begin
                now_d = 1'b0;
                ins_d = 1'b0;
                idx_d = lo_q;
                if (({1'b0, lo_q} + (CW + 1)'(1)) < {1'b0, occ_q}) begin
                  state_d = ST_SHIFT;
                end else begin
                  occ_d = occ_q - CW'(1);
                end
              end
            end
            OP_CLEAR: begin
              now_d = 1'b0;
              occ_d = '0;
            end
            default: begin
              // query and unused codes change nothing
            end
          endcase
        end
      end

      ST_SRCH_CMP: begin
        if (ram_rdata < key_q) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
          eq_d = (ram_rdata == key_q);
        end
        state_d = ST_SRCH_RD;
      end

      ST_SHIFT: begin
        // read the source now, write it to its new slot next cycle
        pend_v_d    = 1'b1;
        pend_addr_d = idx_q;
        idx_d       = src;
        if (last_move) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (ins_q) begin
          state_d = ST_PUT;
        end else begin
          occ_d   = occ_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_PUT: begin
        occ_d   = occ_q + CW'(1);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and ram control
  always_comb begin
    busy_o    = (state_q != ST_IDLE);
    done_o    = (state_q == ST_DONE);
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = pend_addr_q[AW-1:0];
    ram_wdata = ram_rdata;

    case (state_q)
      ST_SRCH_RD: begin
        ram_raddr = mid[AW-1:0];
      end
      ST_SHIFT: begin
        ram_raddr = src[AW-1:0];
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = key_q;
      end
      default: begin
      end
    endcase

    // a move read in the previous cycle lands now
    if (pend_v_q) begin
      ram_we = 1'b1;
    end
  end

  assign position_o      = 7'(lo_q);
  assign was_present_o   = was_q;
  assign now_present_o   = now_q;
  assign rejected_full_o = rej_q;
  assign entry_count_o   = 7'(occ_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      occ_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    op_q        <= op_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    eq_q        <= eq_d;
    idx_q       <= idx_d;
    ins_q       <= ins_d;
    pend_addr_q <= pend_addr_d;
    was_q       <= was_d;
    now_q       <= now_d;
    rej_q       <= rej_d;
  end

  // line store
  smst_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
